@@ design/ldm_pkg.sv @@
// ldm_pkg: shared constants, types and helpers of the drift monitor
// used by every module of the block; no dependencies
`default_nettype none

package ldm_pkg;

    // default data widths
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // gain format, Q0.16 carried in 17 bits so that one is representable
    localparam int          GAIN_BITS  = 17;
    localparam int          GAIN_SHIFT = 16;
    localparam int          GAIN_HALF  = 32768;
    localparam logic [16:0] GAIN_ONE   = 17'h10000;

    // threshold and bias register widths
    localparam int THR_BITS     = 24;
    localparam int POS_THR_BITS = 23;

    // operand slice of the shared multiplier
    localparam int MUL_CHUNK = 32;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;

    typedef logic [CFG_ADDR_BITS-1:0] t_cfg_addr;

    localparam t_cfg_addr REG_LONG_GAIN  = 3'd0;
    localparam t_cfg_addr REG_SHORT_GAIN = 3'd1;
    localparam t_cfg_addr REG_FRZ_NEG    = 3'd2;
    localparam t_cfg_addr REG_FLT_NEG    = 3'd3;
    localparam t_cfg_addr REG_FRZ_POS    = 3'd4;
    localparam t_cfg_addr REG_FLT_POS    = 3'd5;
    localparam t_cfg_addr REG_BIAS       = 3'd6;

    // register reset values
    localparam logic [16:0] LONG_GAIN_RST  = 17'd655;
    localparam logic [16:0] SHORT_GAIN_RST = 17'd6554;
    localparam logic [23:0] FRZ_NEG_RST    = 24'hFFFC18;  // -1000
    localparam logic [23:0] FLT_NEG_RST    = 24'hFFF830;  // -2000
    localparam logic [22:0] FRZ_POS_RST    = 23'd1000;
    localparam logic [22:0] FLT_POS_RST    = 23'd2000;
    localparam logic [23:0] BIAS_RST       = 24'd0;

    // a gain above one acts as one
    function automatic logic [16:0] gain_sat(input logic [16:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

`default_nettype wire

@@ design/long_short_term_drift_monitor_core.sv @@
// long_short_term_drift_monitor_core: slow/fast average drift monitor top level
// depends on ldm_pkg, ldm_mul, ldm_div
//
// Usage:
//  - input stream: tdata carries the signed sample, tuser[0] the restart flag.
//    a transaction is taken only while the core is idle (tready high).
//  - output stream: one result transaction per input transaction, held in an
//    output register until the receiver takes it; a new input is taken while
//    that result waits.
//  - configuration: gains, thresholds and restart bias are written through
//    i_cfg_we / i_cfg_addr / i_cfg_wdata; the user must write them only while
//    the core is idle; the core itself does not enforce this.
//  - sequence: a restart loads both averages and skips the multiplier; an
//    ordinary sample runs the slow and fast updates on the shared slice
//    multiplier (NC slices, 2 by default; no slow update while the slow average
//    is held), and in the freeze band the bit-serial divider computes the ramp.
//  - reset clears both averages, the freeze flag and the output valid, and
//    loads the register defaults.
//  - a stalled receiver holds the result; the core finishes the next sample
//    and waits with it until the output register frees up.
`default_nettype none

module long_short_term_drift_monitor_core #(
    parameter int SAMPLE_BITS   = ldm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = ldm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input stream
    input  wire logic                                   i_s_axis_tvalid,
    output      logic                                   o_s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // sample
    input  wire logic                                   i_s_axis_tuser,  // restart
    // result stream
    output      logic                                   o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // confidence, difference, slow_value, fast_value
    output      logic [((3*SAMPLE_BITS+ldm_pkg::GAIN_BITS+8)/8)*8-1:0] o_m_axis_tdata,
    output      logic [1:0]                             o_m_axis_tuser,  // fault, frozen
    // configuration writes
    input  wire logic                                   i_cfg_we,
    input  wire logic [ldm_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  wire logic [ldm_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata
);

    localparam int S     = SAMPLE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int GB    = ldm_pkg::GAIN_BITS;
    localparam int TB    = ldm_pkg::THR_BITS;
    localparam int AW    = S + F;
    localparam int DW    = AW + 1;
    localparam int PW    = DW + GB;
    localparam int RNDW  = PW - ldm_pkg::GAIN_SHIFT;
    localparam int SUMW  = ((AW > RNDW) ? AW : RNDW) + 1;
    localparam int TW    = TB + F;
    localparam int CMPW  = ((DW > TW) ? DW : TW) + 1;
    localparam int DENW  = TB + 1;
    localparam int BW    = ((S > TB) ? S : TB) + 1;
    localparam int OUTW  = GB + 3 * S + 1;
    localparam int TDOW  = ((3 * S + GB + 8) / 8) * 8;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_SLOW_GO   = 10'b0000000010,
        ST_SLOW_WAIT = 10'b0000000100,
        ST_FAST_GO   = 10'b0000001000,
        ST_FAST_WAIT = 10'b0000010000,
        ST_DIFF      = 10'b0000100000,
        ST_THRESH    = 10'b0001000000,
        ST_DIV_GO    = 10'b0010000000,
        ST_DIV_WAIT  = 10'b0100000000,
        ST_EMIT      = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [GB-1:0]           r_cfg_long_gain;
    logic [GB-1:0]           r_cfg_short_gain;
    logic signed [TB-1:0]    r_cfg_frz_neg;
    logic signed [TB-1:0]    r_cfg_flt_neg;
    logic [ldm_pkg::POS_THR_BITS-1:0] r_cfg_frz_pos;
    logic [ldm_pkg::POS_THR_BITS-1:0] r_cfg_flt_pos;
    logic signed [TB-1:0]    r_cfg_bias;

    // filter state and working registers
    logic signed [S-1:0]     r_x;
    logic signed [AW-1:0]    r_slow;
    logic signed [AW-1:0]    r_fast;
    logic                    r_freeze;
    logic                    r_fault;
    logic signed [DW-1:0]    r_d;
    logic signed [CMPW-1:0]  r_num;
    logic signed [DENW-1:0]  r_den;
    logic [GB-1:0]           r_conf;

    // output register
    logic                    r_out_valid;
    logic                    r_out_fault;
    logic                    r_out_frozen;
    logic [GB-1:0]           r_out_conf;
    logic signed [S:0]       r_out_diff;
    logic signed [S-1:0]     r_out_slow;
    logic signed [S-1:0]     r_out_fast;

    logic in_acc;
    logic out_free;

    // multiplier and divider hookup
    logic                   mul_start;
    logic signed [DW-1:0]   mul_diff;
    logic [GB-1:0]          mul_gain;
    logic                   mul_done;
    logic signed [PW-1:0]   mul_prod;
    logic                   div_start;
    logic                   div_done;
    logic [GB-1:0]          div_quot;

    // datapath nets
    logic signed [S-1:0]    in_x;
    logic signed [BW-1:0]   rs_sum;
    logic signed [S-1:0]    rs_slow;
    logic signed [DW-1:0]   xf_ext;
    logic signed [AW-1:0]   lag_avg;
    logic signed [PW-1:0]   prnd;
    logic signed [RNDW-1:0] rnd;
    logic signed [SUMW-1:0] lag_sum;
    logic signed [SUMW-1:0] avg_hi;
    logic signed [SUMW-1:0] avg_lo;
    logic signed [AW-1:0]   n_lag;
    logic signed [BW-1:0]   smp_hi;
    logic signed [BW-1:0]   smp_lo;
    logic                   neg_side;
    logic signed [TB-1:0]   sel_frz;
    logic signed [TB-1:0]   sel_flt;
    logic signed [CMPW-1:0] d_c;
    logic signed [CMPW-1:0] frz_sc;
    logic signed [CMPW-1:0] flt_sc;
    logic                   freeze_c;
    logic                   fault_c;
    logic signed [CMPW-1:0] num_c;
    logic signed [DENW-1:0] den_c;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_long_gain  <= ldm_pkg::LONG_GAIN_RST;
            r_cfg_short_gain <= ldm_pkg::SHORT_GAIN_RST;
            r_cfg_frz_neg    <= ldm_pkg::FRZ_NEG_RST;
            r_cfg_flt_neg    <= ldm_pkg::FLT_NEG_RST;
            r_cfg_frz_pos    <= ldm_pkg::FRZ_POS_RST;
            r_cfg_flt_pos    <= ldm_pkg::FLT_POS_RST;
            r_cfg_bias       <= ldm_pkg::BIAS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ldm_pkg::REG_LONG_GAIN:  r_cfg_long_gain  <= i_cfg_wdata[GB-1:0];
                ldm_pkg::REG_SHORT_GAIN: r_cfg_short_gain <= i_cfg_wdata[GB-1:0];
                ldm_pkg::REG_FRZ_NEG:    r_cfg_frz_neg    <= i_cfg_wdata;
                ldm_pkg::REG_FLT_NEG:    r_cfg_flt_neg    <= i_cfg_wdata;
                ldm_pkg::REG_FRZ_POS:
                    r_cfg_frz_pos <= i_cfg_wdata[ldm_pkg::POS_THR_BITS-1:0];
                ldm_pkg::REG_FLT_POS:
                    r_cfg_flt_pos <= i_cfg_wdata[ldm_pkg::POS_THR_BITS-1:0];
                ldm_pkg::REG_BIAS:       r_cfg_bias       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // restart load: biased sample clamped to the sample range
    always_comb begin
        in_x    = $signed(i_s_axis_tdata[S-1:0]);
        rs_sum  = BW'(in_x) + BW'(r_cfg_bias);
        smp_hi  = $signed({{(BW-S+1){1'b0}}, {(S-1){1'b1}}});
        smp_lo  = $signed({{(BW-S+1){1'b1}}, {(S-1){1'b0}}});
        if (rs_sum > smp_hi) begin
            rs_sum_clamp: rs_slow = smp_hi[S-1:0];
        end else if (rs_sum < smp_lo) begin
            rs_slow = smp_lo[S-1:0];
        end else begin
            rs_slow = rs_sum[S-1:0];
        end
    end

    // multiplier operands, shared by both averages
    always_comb begin
        xf_ext    = $signed({r_x[S-1], r_x, {F{1'b0}}});
        lag_avg   = (r_state == ST_SLOW_GO || r_state == ST_SLOW_WAIT) ? r_slow : r_fast;
        mul_diff  = xf_ext - DW'(lag_avg);
        mul_gain  = (r_state == ST_SLOW_GO) ? ldm_pkg::gain_sat(r_cfg_long_gain)
                                            : ldm_pkg::gain_sat(r_cfg_short_gain);
        mul_start = (r_state == ST_SLOW_GO && !r_freeze) || (r_state == ST_FAST_GO);
    end

    // rounded update and saturation to the sample range
    always_comb begin
        prnd    = mul_prod + PW'(ldm_pkg::GAIN_HALF);
        rnd     = $signed(prnd[PW-1:ldm_pkg::GAIN_SHIFT]);
        lag_sum = SUMW'(lag_avg) + SUMW'(rnd);
        avg_hi  = $signed({{(SUMW-AW+1){1'b0}}, {(S-1){1'b1}}, {F{1'b0}}});
        avg_lo  = $signed({{(SUMW-AW+1){1'b1}}, {(AW-1){1'b0}}});
        if (lag_sum > avg_hi) begin
            n_lag = avg_hi[AW-1:0];
        end else if (lag_sum < avg_lo) begin
            n_lag = avg_lo[AW-1:0];
        end else begin
            n_lag = lag_sum[AW-1:0];
        end
    end

    // threshold side, flags and ramp operands
    always_comb begin
        neg_side = r_d[DW-1] || (r_d == '0);
        sel_frz  = neg_side ? r_cfg_frz_neg : $signed({1'b0, r_cfg_frz_pos});
        sel_flt  = neg_side ? r_cfg_flt_neg : $signed({1'b0, r_cfg_flt_pos});
        d_c      = CMPW'(r_d);
        frz_sc   = CMPW'($signed({sel_frz, {F{1'b0}}}));
        flt_sc   = CMPW'($signed({sel_flt, {F{1'b0}}}));
        freeze_c = neg_side ? (d_c <= frz_sc) : (d_c >= frz_sc);
        fault_c  = neg_side ? (d_c <= flt_sc) : (d_c >= flt_sc);
        num_c    = neg_side ? (d_c - flt_sc) : (flt_sc - d_c);
        den_c    = neg_side ? (DENW'(sel_frz) - DENW'(sel_flt))
                            : (DENW'(sel_flt) - DENW'(sel_frz));
    end

    assign div_start = (r_state == ST_DIV_GO);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_acc) n_state = i_s_axis_tuser ? ST_EMIT : ST_SLOW_GO;
            ST_SLOW_GO:   n_state = r_freeze ? ST_FAST_GO : ST_SLOW_WAIT;
            ST_SLOW_WAIT: if (mul_done) n_state = ST_FAST_GO;
            ST_FAST_GO:   n_state = ST_FAST_WAIT;
            ST_FAST_WAIT: if (mul_done) n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_THRESH;
            ST_THRESH:    n_state = freeze_c ? ST_DIV_GO : ST_EMIT;
            ST_DIV_GO:    n_state = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) n_state = ST_EMIT;
            ST_EMIT:      if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // state and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slow      <= '0;
            r_fast      <= '0;
            r_freeze    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_acc && i_s_axis_tuser) begin
                r_slow   <= $signed({rs_slow, {F{1'b0}}});
                r_fast   <= $signed({in_x, {F{1'b0}}});
                r_freeze <= 1'b0;
            end
            if (r_state == ST_SLOW_WAIT && mul_done) begin
                r_slow <= n_lag;
            end
            if (r_state == ST_FAST_WAIT && mul_done) begin
                r_fast <= n_lag;
            end
            if (r_state == ST_THRESH) begin
                r_freeze <= freeze_c;
            end
            // output valid
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_x     <= in_x;
            r_d     <= '0;
            r_fault <= 1'b0;
            r_conf  <= ldm_pkg::GAIN_ONE;
        end
        if (r_state == ST_DIFF) begin
            r_d <= DW'(r_slow) - DW'(r_fast);
        end
        if (r_state == ST_THRESH) begin
            r_fault <= fault_c;
            r_num   <= num_c;
            r_den   <= den_c;
            r_conf  <= ldm_pkg::GAIN_ONE;
        end
        if (r_state == ST_DIV_WAIT && div_done) begin
            r_conf <= div_quot;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_fault  <= r_fault;
            r_out_frozen <= r_freeze;
            r_out_conf   <= r_conf;
            r_out_diff   <= r_d[DW-1:F];
            r_out_slow   <= r_slow[AW-1:F];
            r_out_fast   <= r_fast[AW-1:F];
        end
    end

    ldm_mul #(
        .DIFF_BITS (DW),
        .GAIN_BITS (GB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_diff  (mul_diff),
        .i_gain  (mul_gain),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ldm_div #(
        .NUM_BITS  (CMPW),
        .DEN_BITS  (DENW),
        .FRAC_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // result stream
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDOW'({r_out_fast, r_out_slow, r_out_diff, r_out_conf});
    assign o_m_axis_tuser  = {r_out_frozen, r_out_fault};

endmodule

`default_nettype wire

@@ design/ldm_mul.sv @@
// ldm_mul: iterative signed-by-unsigned multiplier, one 32-bit slice per cycle
// depends on ldm_pkg
`default_nettype none

module ldm_mul #(
    parameter int DIFF_BITS = ldm_pkg::SAMPLE_BITS_DEF + ldm_pkg::FRACTION_BITS_DEF + 1,
    parameter int GAIN_BITS = ldm_pkg::GAIN_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [DIFF_BITS-1:0]           i_diff,
    input  wire logic        [GAIN_BITS-1:0]           i_gain,
    output      logic                                  o_done,
    output      logic signed [DIFF_BITS+GAIN_BITS-1:0] o_prod
);

    localparam int CH   = ldm_pkg::MUL_CHUNK;
    localparam int PW   = DIFF_BITS + GAIN_BITS;
    localparam int NC   = (PW + CH - 1) / CH;
    localparam int OPW  = NC * CH;
    localparam int CNTW = $clog2(NC + 1);

    logic [OPW-1:0]       r_op;
    logic [GAIN_BITS-1:0] r_gain;
    logic [PW-1:0]        r_acc;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CH-1:0]           slice;
    logic [CH+GAIN_BITS-1:0] part;
    logic [PW-1:0]           n_acc;

    // top slice first, accumulator shifts up one slice per cycle
    always_comb begin
        slice = r_op[OPW-1 -: CH];
        part  = slice * r_gain;
        n_acc = (r_acc << CH) + PW'(part);
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and accumulator, sign extended so the product wraps correctly
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= OPW'(i_diff);
            r_gain <= i_gain;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_op  <= r_op << CH;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_acc);

endmodule

`default_nettype wire

@@ design/ldm_div.sv @@
// ldm_div: restoring divider for the confidence ramp, one quotient bit per cycle
// depends on ldm_pkg
`default_nettype none

module ldm_div #(
    parameter int NUM_BITS  = 43,
    parameter int DEN_BITS  = ldm_pkg::THR_BITS + 1,
    parameter int FRAC_BITS = ldm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [NUM_BITS-1:0] i_num,
    input  wire logic signed [DEN_BITS-1:0] i_den,
    output      logic                       o_done,
    output      logic [ldm_pkg::GAIN_BITS-1:0] o_quot
);

    localparam int NEGW = NUM_BITS + 1;
    localparam int DVW  = DEN_BITS + 1 + FRAC_BITS;
    localparam int RW   = ((NEGW > DEN_BITS + FRAC_BITS) ? NEGW : DEN_BITS + FRAC_BITS) + 1;
    localparam int CNTW = $clog2(ldm_pkg::GAIN_SHIFT + 1);

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_CHECK = 3'b010,
        DV_STEP  = 3'b100
    } t_div_state;

    t_div_state                    r_state;
    logic signed [RW-1:0]          r_rem;
    logic signed [RW-1:0]          r_dvs;
    logic [ldm_pkg::GAIN_BITS-1:0] r_quot;
    logic [CNTW-1:0]               r_cnt;
    logic                          r_done;

    logic signed [NEGW-1:0]     num_ext;
    logic signed [DEN_BITS:0]   den_ext;
    logic signed [DEN_BITS:0]   den_mag;
    logic signed [RW-1:0]       rem_load;
    logic signed [RW-1:0]       dvs_load;
    logic signed [RW-1:0]       rem_dbl;

    // sign normalization so the divisor is positive
    always_comb begin
        num_ext  = NEGW'(i_num);
        den_ext  = (DEN_BITS+1)'(i_den);
        den_mag  = den_ext[DEN_BITS] ? -den_ext : den_ext;
        rem_load = den_ext[DEN_BITS] ? -RW'(num_ext) : RW'(num_ext);
        dvs_load = RW'($signed({den_mag, {FRAC_BITS{1'b0}}}));
        rem_dbl  = r_rem <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        if (i_den == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= DV_CHECK;
                        end
                    end
                end
                DV_CHECK: begin
                    // empty or full ramp ends here
                    if (r_rem <= 0 || r_rem >= r_dvs) begin
                        r_done  <= 1'b1;
                        r_state <= DV_IDLE;
                    end else begin
                        r_cnt   <= CNTW'(ldm_pkg::GAIN_SHIFT);
                        r_state <= DV_STEP;
                    end
                end
                DV_STEP: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= DV_IDLE;
                    end
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    // remainder, divisor and quotient
    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_rem  <= rem_load;
                    r_dvs  <= dvs_load;
                    r_quot <= '0;
                end
            end
            DV_CHECK: begin
                if (r_rem <= 0) begin
                    r_quot <= '0;
                end else if (r_rem >= r_dvs) begin
                    r_quot <= ldm_pkg::GAIN_ONE;
                end else begin
                    r_quot <= '0;
                end
            end
            DV_STEP: begin
                if (rem_dbl >= r_dvs) begin
                    r_rem  <= rem_dbl - r_dvs;
                    r_quot <= {r_quot[ldm_pkg::GAIN_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_dbl;
                    r_quot <= {r_quot[ldm_pkg::GAIN_BITS-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ design/ldm_checker.sv @@
// ldm_checker: port-level assertions for the drift monitor, bound to the top level
// depends on ldm_pkg and long_short_term_drift_monitor_core
`default_nettype none

module ldm_checker #(
    parameter int SAMPLE_BITS = ldm_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_s_axis_tvalid,
    input wire logic                                   o_s_axis_tready,
    input wire logic                                   o_m_axis_tvalid,
    input wire logic                                   i_m_axis_tready,
    input wire logic [((3*SAMPLE_BITS+ldm_pkg::GAIN_BITS+8)/8)*8-1:0] o_m_axis_tdata,
    input wire logic [1:0]                             o_m_axis_tuser
);

    logic [ldm_pkg::GAIN_BITS-1:0] conf;

    assign conf = o_m_axis_tdata[ldm_pkg::GAIN_BITS-1:0];

    // one sample at a time: ready drops after each input transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready still high after input transaction");

    // confidence never exceeds one
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (conf <= ldm_pkg::GAIN_ONE))
        else $error("confidence above one");

    // outside the freeze band confidence is full
    a_thawed_full_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |-> (conf == ldm_pkg::GAIN_ONE))
        else $error("confidence below one while not frozen");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind long_short_term_drift_monitor_core ldm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ldm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the slow/fast drift monitor core
// drives sample transactions and register writes, predicts every result
// transaction and compares it field by field; depends on ldm_pkg and the core
`timescale 1ns / 100ps

module tb_top;
    import ldm_pkg::*;

    localparam int     FRAC        = 16;
    localparam longint SMP_MIN     = -(64'sd1 <<< 23);
    localparam longint SMP_MAX     = (64'sd1 <<< 23) - 1;
    localparam longint AVG_MIN     = SMP_MIN <<< FRAC;
    localparam longint AVG_MAX     = SMP_MAX <<< FRAC;
    localparam int     SETTLE      = 40;    // idle cycles before a register write
    localparam int     TAIL        = 64;    // idle cycles after the final drain
    localparam int     HOLD_CYCLES = 300;
    localparam int     STALL_LIMIT = 3000;  // well above the hold-off and idle stalls
    localparam int     PRINT_CAP   = 30;
    localparam int     PHASE_ITEMS = 50;

    // one result transaction, unpacked
    typedef struct packed {
        logic        fault;
        logic        frozen;
        logic [16:0] conf;
        logic [24:0] diff;
        logic [23:0] slow;
        logic [23:0] fast;
    } drift_t;

    // one row of the directed table: a register write or a sample
    typedef struct {
        bit          is_cfg;
        t_cfg_addr   addr;
        logic [23:0] value;
        logic [23:0] smp;
        bit          restart;
        bit          typed;
        drift_t      want;
    } plan_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [23:0] s_data;
    logic        s_user;
    logic        m_ready;
    logic        cfg_we;
    t_cfg_addr   cfg_addr;
    logic [23:0] cfg_wdata;

    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [95:0]  o_m_axis_tdata;
    wire [1:0]   o_m_axis_tuser;

    // predictor copy of the registers and of the filter state
    logic [16:0] long_gain_r;
    logic [16:0] short_gain_r;
    logic [23:0] frz_neg_r;
    logic [23:0] flt_neg_r;
    logic [22:0] frz_pos_r;
    logic [22:0] flt_pos_r;
    logic [23:0] bias_r;
    longint      slow_avg;
    longint      fast_avg;
    bit          hold_slow;

    drift_t      drift_results_q[$];
    plan_row_t   plan[$];
    int          err_count;
    int          result_idx;
    int          src_idle_pct;
    int          dst_idle_pct;
    int          hold_reqs;
    int          stall_cycles;

    long_short_term_drift_monitor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint eff_gain(logic [16:0] g);
        return (g > GAIN_ONE) ? 64'sd65536 : longint'(g);
    endfunction

    function automatic longint rand_signed(longint amp);
        return longint'($urandom_range(0, 32'(2 * amp))) - amp;
    endfunction

    // avg + round(k * (x - avg) / 2^16), ties toward plus infinity
    function automatic longint ema_step(longint avg, longint x, longint k);
        longint diff;
        longint hi;
        longint lo;
        longint part;
        diff = x - avg;
        hi   = diff >>> 16;
        lo   = diff - (hi <<< 16);
        part = (lo * k + 32768) >>> 16;
        return avg + hi * k + part;
    endfunction

    // floor(65536 * num / (den * 2^16)) clamped to 0..one, zero width gives 0
    function automatic logic [16:0] ramp_confidence(longint num, longint den);
        longint dd;
        if (den == 0) return 17'd0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) return 17'd0;
        dd = den <<< FRAC;
        if (num >= dd) return GAIN_ONE;
        return 17'((num <<< 16) / dd);
    endfunction

    // advance the predictor by one sample and return its result
    function automatic drift_t drift_predict(logic [23:0] smp, bit restart);
        drift_t r;
        longint x;
        longint d;
        longint frz;
        longint flt;
        bit     flt_hit;
        x       = longint'($signed(smp));
        d       = 0;
        flt_hit = 1'b0;
        r.conf  = GAIN_ONE;
        if (restart) begin
            slow_avg  = clip(x + longint'($signed(bias_r)), SMP_MIN, SMP_MAX) <<< FRAC;
            fast_avg  = x <<< FRAC;
            hold_slow = 1'b0;
        end else begin
            if (!hold_slow)
                slow_avg = clip(ema_step(slow_avg, x <<< FRAC, eff_gain(long_gain_r)),
                                AVG_MIN, AVG_MAX);
            fast_avg = clip(ema_step(fast_avg, x <<< FRAC, eff_gain(short_gain_r)),
                            AVG_MIN, AVG_MAX);
            d = slow_avg - fast_avg;
            if (d <= 0) begin
                frz       = longint'($signed(frz_neg_r));
                flt       = longint'($signed(flt_neg_r));
                hold_slow = d <= (frz <<< FRAC);
                flt_hit   = d <= (flt <<< FRAC);
                r.conf    = hold_slow ? ramp_confidence(d - (flt <<< FRAC), frz - flt)
                                      : GAIN_ONE;
            end else begin
                frz       = longint'(frz_pos_r);
                flt       = longint'(flt_pos_r);
                hold_slow = d >= (frz <<< FRAC);
                flt_hit   = d >= (flt <<< FRAC);
                r.conf    = hold_slow ? ramp_confidence((flt <<< FRAC) - d, flt - frz)
                                      : GAIN_ONE;
            end
        end
        r.fault  = flt_hit;
        r.frozen = hold_slow;
        r.diff   = 25'(d >>> FRAC);
        r.slow   = 24'(slow_avg >>> FRAC);
        r.fast   = 24'(fast_avg >>> FRAC);
        return r;
    endfunction

    // freeze and fault magnitudes of one side, sometimes crossed or equal
    function automatic void pick_band(output longint frz, output longint flt);
        int scale;
        scale = $urandom_range(3, 21);
        frz   = longint'($urandom_range(0, 1 << scale));
        flt   = frz + longint'($urandom_range(0, 1 << scale));
        case ($urandom_range(0, 5))
            0: begin
                flt = frz;
                frz = frz + longint'($urandom_range(1, 1 << scale));
            end
            1: flt = frz;
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 24'(GAIN_ONE);
            1: return 24'($urandom_range(65537, 131071));
            2: return 24'($urandom_range(1, 2000));
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic void add_write(t_cfg_addr addr, logic [23:0] value);
        plan_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.value  = value;
        plan.push_back(row);
    endfunction

    function automatic void add_sample(logic [23:0] smp, bit restart, bit typed,
                                       drift_t want);
        plan_row_t row;
        row         = '{default: '0};
        row.smp     = smp;
        row.restart = restart;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (err_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     result_idx, what, got, want);
        err_count++;
    endtask

    // one input transaction; called and left at a falling edge
    task automatic send_item(logic [23:0] smp, bit restart, bit typed, drift_t want);
        drift_t pred;
        while (roll(src_idle_pct)) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_user  <= restart;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pred = drift_predict(smp, restart);
        drift_results_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain(int settle);
        s_valid <= 1'b0;
        do @(negedge i_clk); while (drift_results_q.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_addr addr, logic [23:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        case (addr)
            REG_LONG_GAIN:  long_gain_r  = value[16:0];
            REG_SHORT_GAIN: short_gain_r = value[16:0];
            REG_FRZ_NEG:    frz_neg_r    = value;
            REG_FLT_NEG:    flt_neg_r    = value;
            REG_FRZ_POS:    frz_pos_r    = value[22:0];
            REG_FLT_POS:    flt_pos_r    = value[22:0];
            REG_BIAS:       bias_r       = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // register setting of one random phase: defaults, both extremes, then random
    task automatic set_phase_config(int p);
        logic [23:0] g_long;
        logic [23:0] g_short;
        logic [23:0] t_frz_neg;
        logic [23:0] t_flt_neg;
        logic [23:0] t_frz_pos;
        logic [23:0] t_flt_pos;
        logic [23:0] t_bias;
        longint      frz;
        longint      flt;
        case (p)
            0: begin
                g_long    = 24'(LONG_GAIN_RST);
                g_short   = 24'(SHORT_GAIN_RST);
                t_frz_neg = FRZ_NEG_RST;
                t_flt_neg = FLT_NEG_RST;
                t_frz_pos = 24'(FRZ_POS_RST);
                t_flt_pos = 24'(FLT_POS_RST);
                t_bias    = BIAS_RST;
            end
            1: begin
                g_long    = 24'(GAIN_ONE);
                g_short   = 24'(GAIN_ONE);
                t_frz_neg = 24'h800000;
                t_flt_neg = 24'h800000;
                t_frz_pos = 24'h7FFFFF;
                t_flt_pos = 24'h7FFFFF;
                t_bias    = 24'h7FFFFF;
            end
            2: begin
                g_long    = 24'd0;
                g_short   = 24'(GAIN_ONE);
                t_frz_neg = 24'd0;
                t_flt_neg = 24'd0;
                t_frz_pos = 24'd0;
                t_flt_pos = 24'd0;
                t_bias    = 24'h800000;
            end
            default: begin
                g_long  = pick_gain();
                g_short = pick_gain();
                pick_band(frz, flt);
                t_frz_neg = 24'(-frz);
                t_flt_neg = 24'(-flt);
                // negative thresholds of the wrong sign now and then
                if (roll(15)) t_frz_neg = 24'($urandom);
                if (roll(15)) t_flt_neg = 24'($urandom);
                pick_band(frz, flt);
                t_frz_pos = 24'(frz);
                t_flt_pos = 24'(flt);
                case ($urandom_range(0, 2))
                    0:       t_bias = 24'd0;
                    1:       t_bias = 24'(rand_signed(1000));
                    default: t_bias = 24'($urandom);
                endcase
            end
        endcase
        drain(SETTLE);
        write_reg(REG_LONG_GAIN, g_long);
        write_reg(REG_SHORT_GAIN, g_short);
        write_reg(REG_FRZ_NEG, t_frz_neg);
        write_reg(REG_FLT_NEG, t_flt_neg);
        write_reg(REG_FRZ_POS, t_frz_pos);
        write_reg(REG_FLT_POS, t_flt_pos);
        write_reg(REG_BIAS, t_bias);
    endtask

    // drifting level with noise, jumps, restarts, full-range and extreme samples
    task automatic run_phase(int n, bit pause_mid);
        longint level;
        longint x;
        int     kind;
        bit     restart;
        level = rand_signed(longint'(1) << $urandom_range(4, 23));
        level = clip(level, SMP_MIN, SMP_MAX);
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) drain(0);
            if (roll(10)) level = clip(level + rand_signed(longint'(1) <<
                                      $urandom_range(4, 23)), SMP_MIN, SMP_MAX);
            kind    = $urandom_range(0, 99);
            restart = 1'b0;
            if (kind < 5) begin
                restart = 1'b1;
                x       = level;
            end else if (kind < 20) begin
                x = longint'($signed(24'($urandom)));
            end else if (kind < 26) begin
                x = roll(50) ? SMP_MAX : SMP_MIN;
            end else begin
                x = clip(level + rand_signed(longint'(1) << $urandom_range(0, 22)),
                         SMP_MIN, SMP_MAX);
            end
            send_item(24'(x), restart, 1'b0, '0);
        end
    endtask

    // result receiver, with random idling and an occasional long hold-off
    initial begin
        int hold_left;
        int seen;
        m_ready   = 1'b0;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != seen) begin
                seen      = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !roll(dst_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        drift_t got;
        drift_t want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.conf   = o_m_axis_tdata[16:0];
            got.diff   = o_m_axis_tdata[41:17];
            got.slow   = o_m_axis_tdata[65:42];
            got.fast   = o_m_axis_tdata[89:66];
            got.fault  = o_m_axis_tuser[0];
            got.frozen = o_m_axis_tuser[1];
            if (drift_results_q.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(got.diff), 64'd0);
            end else begin
                want = drift_results_q.pop_front();
                if (got.fault !== want.fault)
                    report_mismatch("fault", 64'(got.fault), 64'(want.fault));
                if (got.frozen !== want.frozen)
                    report_mismatch("frozen", 64'(got.frozen), 64'(want.frozen));
                if (got.conf !== want.conf)
                    report_mismatch("confidence", 64'(got.conf), 64'(want.conf));
                if (got.diff !== want.diff)
                    report_mismatch("difference", 64'(got.diff), 64'(want.diff));
                if (got.slow !== want.slow)
                    report_mismatch("slow_value", 64'(got.slow), 64'(want.slow));
                if (got.fast !== want.fast)
                    report_mismatch("fast_value", 64'(got.fast), 64'(want.fast));
            end
            result_idx++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial begin
        bit in_cfg;
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_LONG_GAIN;
        cfg_wdata    = '0;
        i_rst_n      = 1'b0;
        err_count    = 0;
        result_idx   = 0;
        hold_reqs    = 0;
        stall_cycles = 0;
        src_idle_pct = 30;
        dst_idle_pct = 82;
        in_cfg       = 1'b0;
        long_gain_r  = LONG_GAIN_RST;
        short_gain_r = SHORT_GAIN_RST;
        frz_neg_r    = FRZ_NEG_RST;
        flt_neg_r    = FLT_NEG_RST;
        frz_pos_r    = FRZ_POS_RST;
        flt_pos_r    = FLT_POS_RST;
        bias_r       = BIAS_RST;
        slow_avg     = 0;
        fast_avg     = 0;
        hold_slow    = 1'b0;

        // directed table: values after reset, full-scale steps, restarts
        add_sample(24'd0, 1'b0, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        add_sample(24'h7FFFFF, 1'b1, 1'b1,
                   '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'h7FFFFF, 24'h7FFFFF});
        add_sample(24'h7FFFFF, 1'b0, 1'b1,
                   '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'h7FFFFF, 24'h7FFFFF});
        add_sample(24'h800000, 1'b1, 1'b1,
                   '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'h800000, 24'h800000});
        add_sample(24'h7FFFFF, 1'b0, 1'b0, '0);
        add_sample(24'h7FFFFF, 1'b0, 1'b0, '0);
        add_sample(24'h7FFFFF, 1'b0, 1'b0, '0);
        add_sample(24'd0, 1'b1, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        // fast average drops below slow: positive freeze band and its ramp
        add_sample(24'(-20000), 1'b0, 1'b0, '0);
        add_sample(24'(-20000), 1'b0, 1'b0, '0);
        add_sample(24'd1500, 1'b0, 1'b0, '0);
        // slow gain above one acts as one, fast average stands still
        add_write(REG_LONG_GAIN, 24'h01FFFF);
        add_write(REG_SHORT_GAIN, 24'd0);
        add_sample(24'd0, 1'b1, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        add_sample(24'd5000, 1'b0, 1'b0, '0);
        // equal freeze and fault thresholds: no ramp width
        add_write(REG_FRZ_POS, 24'd3000);
        add_write(REG_FLT_POS, 24'd3000);
        add_sample(24'd0, 1'b1, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        add_sample(24'd3000, 1'b0, 1'b0, '0);
        // fault threshold inside the freeze threshold
        add_write(REG_FRZ_POS, 24'd4000);
        add_write(REG_FLT_POS, 24'd2000);
        add_sample(24'd0, 1'b1, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        add_sample(24'd3000, 1'b0, 1'b0, '0);
        add_sample(24'd5000, 1'b0, 1'b0, '0);
        // negative thresholds with the wrong sign
        add_write(REG_FRZ_NEG, 24'd500);
        add_write(REG_FLT_NEG, 24'd800);
        add_sample(24'd0, 1'b1, 1'b1, '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'd0, 24'd0});
        add_sample(24'd0, 1'b0, 1'b0, '0);
        add_sample(24'(-3000), 1'b0, 1'b0, '0);
        // restart bias saturating at both ends
        add_write(REG_BIAS, 24'h7FFFFF);
        add_sample(24'd100, 1'b1, 1'b1,
                   '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'h7FFFFF, 24'd100});
        add_write(REG_BIAS, 24'h800000);
        add_sample(24'hFFFFFB, 1'b1, 1'b1,
                   '{1'b0, 1'b0, GAIN_ONE, 25'd0, 24'h800000, 24'hFFFFFB});
        add_sample(24'h7FFFFF, 1'b0, 1'b0, '0);

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // walk the directed table
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!in_cfg) drain(SETTLE);
                in_cfg = 1'b1;
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                in_cfg = 1'b0;
                send_item(plan[i].smp, plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        // random phases under changing settings and idling
        for (int p = 0; p < 8; p++) begin
            set_phase_config(p);
            if (p < 3) begin
                src_idle_pct = 30;
                dst_idle_pct = 82;
            end else if (p < 6) begin
                src_idle_pct = 82;
                dst_idle_pct = 30;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            // long receiver hold-off while samples keep coming
            if (p == 6) hold_reqs++;
            run_phase(PHASE_ITEMS, p == 2);
        end

        drain(TAIL);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
